>>> src/ppsim_pkg.sv
`default_nettype none

package ppsim_pkg;

    // Default sizes of the pool and of the sine table.
    localparam int MAX_PARTICLES_DEF = 64;
    localparam int SINE_DEPTH_DEF    = 256;

    // Register map, one 32-bit register every four bytes.
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_SEED     = 3'd0;
    localparam logic [2:0] REG_RATE     = 3'd1;
    localparam logic [2:0] REG_ANGLES   = 3'd2;
    localparam logic [2:0] REG_SPEED    = 3'd3;
    localparam logic [2:0] REG_SSPREAD  = 3'd4;
    localparam logic [2:0] REG_BLIFE    = 3'd5;
    localparam logic [2:0] REG_LSPREAD  = 3'd6;
    localparam logic [2:0] REG_GRAVITY  = 3'd7;

    // Lifetime limits in seconds, Q8.16.
    localparam logic [23:0] LIFE_FLOOR = 24'd3277;
    localparam logic [23:0] AGE_MAX    = 24'hFFFFFF;

    // Input word.
    typedef struct packed {
        logic               func;
        logic [15:0]        dt;
        logic signed [31:0] emit_x;
        logic signed [31:0] emit_y;
        logic               emitting;
        logic [6:0]         burst_count;
    } t_in;

    // Result word.
    typedef struct packed {
        logic               has_particle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [7:0]         life_frac;
        logic [6:0]         live_count;
        logic               last;
    } t_out;

    // One particle as held in the pool memory.
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [23:0] age;
        logic [23:0] life;
    } t_rec;

    // Sine of a phase given in turns (32-bit fraction), Q16, from a seven-term
    // Taylor series on the first quadrant. Evaluated only at elaboration.
    function automatic logic signed [17:0] sine_value(input logic [31:0] phase);
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          val;
        r = {34'd0, phase[29:0]};
        if (phase[30]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * 64'd6746518852) >> 32;
        term = x;
        sum  = longint'(x);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        val  = (sum + 64'sd8192) >>> 14;
        if (val > 64'sd65536) begin
            val = 64'sd65536;
        end
        if (val < 64'sd0) begin
            val = 64'sd0;
        end
        if (phase[31]) begin
            val = -val;
        end
        return val[17:0];
    endfunction

endpackage

`default_nettype wire

>>> src/particle_pool_simulator.sv
`default_nettype none

// Channel   | Signals                         | Direction
// ----------+---------------------------------+----------
// input     | i_in_valid, o_in_stall, i_in    | in
// result    | o_out_valid, i_out_stall, o_out | out
// config    | psel, penable, pwrite, paddr,   | in/out
//           | pwdata, prdata, pready          |
//
// Steps: after setup, a word runs the spawn steps for each spawned particle,
// the update steps for each particle on a tick and a move step for each
// particle that expires, then starts the listing; results wait on output stall.
// Everything goes through one shared 33x32 multiplier and one restoring
// divider step, under a single sequencer.
// Reset is synchronous and active low; the pool memory needs no clearing pass.
// The input is stalled from acceptance until the last result word is taken.

module particle_pool_simulator #(
    parameter int MAX_PARTICLES    = ppsim_pkg::MAX_PARTICLES_DEF,
    parameter int SINE_TABLE_DEPTH = ppsim_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire ppsim_pkg::t_in                 i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output ppsim_pkg::t_out                     o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ppsim_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int IW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTICLES);

    // Sequencer states.
    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_ACC_MUL   = 5'd1;
    localparam logic [4:0] S_ACC_ADD   = 5'd2;
    localparam logic [4:0] S_SP_CHK    = 5'd3;
    localparam logic [4:0] S_DRAW      = 5'd4;
    localparam logic [4:0] S_DMUL      = 5'd5;
    localparam logic [4:0] S_DADD      = 5'd6;
    localparam logic [4:0] S_COS       = 5'd7;
    localparam logic [4:0] S_VXM       = 5'd8;
    localparam logic [4:0] S_VYM       = 5'd9;
    localparam logic [4:0] S_SP_WR     = 5'd10;
    localparam logic [4:0] S_TK_CHK    = 5'd11;
    localparam logic [4:0] S_TK_RD     = 5'd12;
    localparam logic [4:0] S_TK_VY     = 5'd13;
    localparam logic [4:0] S_TK_MX     = 5'd14;
    localparam logic [4:0] S_TK_X      = 5'd15;
    localparam logic [4:0] S_TK_MY     = 5'd16;
    localparam logic [4:0] S_TK_Y      = 5'd17;
    localparam logic [4:0] S_TK_DEC    = 5'd18;
    localparam logic [4:0] S_TK_MV     = 5'd19;
    localparam logic [4:0] S_OUT_START = 5'd20;
    localparam logic [4:0] S_OUT_RD    = 5'd21;
    localparam logic [4:0] S_OUT_DIV   = 5'd22;
    localparam logic [4:0] S_OUT_PUT   = 5'd23;
    localparam logic [4:0] S_OUT_WAIT  = 5'd24;

    // Which random draw is in progress.
    localparam logic [1:0] DRAW_ANG  = 2'd0;
    localparam logic [1:0] DRAW_SPD  = 2'd1;
    localparam logic [1:0] DRAW_LIFE = 2'd2;

    logic [4:0]          r_state;
    logic [31:0]         r_seed;
    logic [30:0]         r_rate;
    logic [31:0]         r_angles;
    logic [30:0]         r_speed;
    logic [30:0]         r_sspread;
    logic [23:0]         r_blife;
    logic [23:0]         r_lspread;
    logic [31:0]         r_grav;
    logic [31:0]         r_rng;
    logic [15:0]         r_acc;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_i;
    logic [15:0]         r_nspawn;
    logic                r_func;
    logic [15:0]         r_dt;
    logic [31:0]         r_ex;
    logic [31:0]         r_ey;
    logic [1:0]          r_draw;
    logic signed [24:0]  r_s;
    logic signed [64:0]  r_prod;
    logic [15:0]         r_ang;
    logic [30:0]         r_sp;
    logic [23:0]         r_life;
    logic signed [17:0]  r_trig;
    logic [31:0]         r_vx;
    ppsim_pkg::t_rec     r_rec;
    logic [23:0]         r_rem;
    logic [7:0]          r_q;
    logic [2:0]          r_k;
    logic                r_out_valid;
    ppsim_pkg::t_out     r_out;

    logic                n_in_acc;
    logic                n_out_acc;
    logic                n_cfg_wr;
    logic [31:0]         n_xs1;
    logic [31:0]         n_xs2;
    logic [31:0]         n_rng;
    logic signed [32:0]  n_mul_a;
    logic signed [31:0]  n_mul_b;
    logic [31:0]         n_acc_sum;
    logic [31:0]         n_step;
    logic signed [33:0]  n_spd_sum;
    logic signed [26:0]  n_life_sum;
    logic [24:0]         n_age_sum;
    logic [15:0]         n_trig_ang;
    logic [IW+16:0]      n_iprod;
    logic [IW-1:0]       n_idx;
    logic [24:0]         n_rem2;
    logic [24:0]         n_rem_sub;
    logic                n_rem_ge;
    logic [CW-1:0]       n_last_idx;
    logic [CW-1:0]       n_next_i;
    logic                n_we;
    logic [AW-1:0]       n_waddr;
    ppsim_pkg::t_rec     n_wdata;
    logic [AW-1:0]       n_raddr;
    ppsim_pkg::t_rec     n_new;
    ppsim_pkg::t_rec     w_rdata;
    logic signed [17:0]  w_sin [SINE_TABLE_DEPTH];

    // Constant sine table, one entry per step of the turn.
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sin
        localparam longint unsigned PHASE =
            (longint'(k) << 32) / SINE_TABLE_DEPTH;
        assign w_sin[k] = ppsim_pkg::sine_value(PHASE[31:0]);
    end

    assign n_in_acc  = i_in_valid && !o_in_stall;
    assign n_out_acc = r_out_valid && !i_out_stall;
    assign n_cfg_wr  = psel && penable && pwrite;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            ppsim_pkg::REG_SEED:    prdata = r_seed;
            ppsim_pkg::REG_RATE:    prdata = {1'b0, r_rate};
            ppsim_pkg::REG_ANGLES:  prdata = r_angles;
            ppsim_pkg::REG_SPEED:   prdata = {1'b0, r_speed};
            ppsim_pkg::REG_SSPREAD: prdata = {1'b0, r_sspread};
            ppsim_pkg::REG_BLIFE:   prdata = {8'd0, r_blife};
            ppsim_pkg::REG_LSPREAD: prdata = {8'd0, r_lspread};
            ppsim_pkg::REG_GRAVITY: prdata = r_grav;
            default:                prdata = '0;
        endcase
    end

    // Next value of the xorshift generator.
    assign n_xs1 = r_rng ^ (r_rng << 13);
    assign n_xs2 = n_xs1 ^ (n_xs1 >> 17);
    assign n_rng = n_xs2 ^ (n_xs2 << 5);

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_ACC_MUL: begin
                n_mul_a = {2'b00, r_rate};
                n_mul_b = {16'd0, r_dt};
            end
            S_DMUL: begin
                n_mul_a = {{8{r_s[24]}}, r_s};
                unique case (r_draw)
                    DRAW_ANG: n_mul_b = {16'd0, r_angles[15:0]};
                    DRAW_SPD: n_mul_b = {1'b0, r_sspread};
                    default:  n_mul_b = {8'd0, r_lspread};
                endcase
            end
            S_VXM, S_VYM: begin
                n_mul_a = {{15{r_trig[17]}}, r_trig};
                n_mul_b = {1'b0, r_sp};
            end
            S_TK_RD: begin
                n_mul_a = {r_grav[31], r_grav};
                n_mul_b = {16'd0, r_dt};
            end
            S_TK_MX: begin
                n_mul_a = {r_rec.vel_x[31], r_rec.vel_x};
                n_mul_b = {16'd0, r_dt};
            end
            S_TK_MY: begin
                n_mul_a = {r_rec.vel_y[31], r_rec.vel_y};
                n_mul_b = {16'd0, r_dt};
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // Sums that narrow the registered product.
    assign n_step     = r_prod[47:16];
    assign n_acc_sum  = {16'd0, r_acc} + r_prod[47:16];
    assign n_spd_sum  = $signed({3'b000, r_speed}) + $signed({r_prod[56], r_prod[56:24]});
    assign n_life_sum = $signed({3'b000, r_blife}) + $signed({r_prod[49], r_prod[49:24]});
    assign n_age_sum  = {1'b0, r_rec.age} + {9'd0, r_dt};

    // Sine table lookup; the cosine uses a quarter turn more.
    assign n_trig_ang = (r_state == S_COS) ? (r_ang + 16'h4000) : r_ang;
    assign n_iprod    = (IW+17)'(n_trig_ang) * (IW+17)'(SINE_TABLE_DEPTH);
    assign n_idx      = n_iprod[IW+15:16];

    // One step of the restoring divider for age over life.
    assign n_rem2    = {r_rem, 1'b0};
    assign n_rem_ge  = (n_rem2 >= {1'b0, r_rec.life});
    assign n_rem_sub = n_rem2 - {1'b0, r_rec.life};

    assign n_last_idx = r_cnt - CW'(1);
    assign n_next_i   = r_i + CW'(1);

    // Freshly spawned particle.
    always_comb begin
        n_new.pos_x = r_ex;
        n_new.pos_y = r_ey;
        n_new.vel_x = r_vx;
        n_new.vel_y = n_step;
        n_new.age   = '0;
        n_new.life  = r_life;
    end

    // Pool memory ports.
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_i[AW-1:0];
        n_wdata = r_rec;
        unique case (r_state)
            S_SP_WR: begin
                n_we    = 1'b1;
                n_waddr = r_cnt[AW-1:0];
                n_wdata = n_new;
            end
            S_TK_DEC: begin
                n_we = (r_rec.age < r_rec.life);
            end
            S_TK_MV: begin
                n_we    = 1'b1;
                n_wdata = w_rdata;
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_TK_DEC:    n_raddr = n_last_idx[AW-1:0];
            S_OUT_START: n_raddr = '0;
            S_OUT_WAIT:  n_raddr = n_next_i[AW-1:0];
            default:     n_raddr = r_i[AW-1:0];
        endcase
    end

    ppsim_ram #(
        .WIDTH ($bits(ppsim_pkg::t_rec)),
        .DEPTH (MAX_PARTICLES)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // Datapath registers that need no reset.
    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
        if (n_in_acc) begin
            r_func <= i_in.func;
            r_dt   <= i_in.dt;
            r_ex   <= i_in.emit_x;
            r_ey   <= i_in.emit_y;
        end
        unique case (r_state)
            S_DRAW: begin
                r_s <= {~n_rng[31], n_rng[30:8], 1'b0};
            end
            S_DADD: begin
                unique case (r_draw)
                    DRAW_ANG: r_ang <= r_angles[31:16] + r_prod[39:24];
                    DRAW_SPD: begin
                        if (n_spd_sum < 0) begin
                            r_sp <= '0;
                        end else if (n_spd_sum > 34'sh7FFF_FFFF) begin
                            r_sp <= 31'h7FFF_FFFF;
                        end else begin
                            r_sp <= n_spd_sum[30:0];
                        end
                    end
                    default: begin
                        if (n_life_sum < $signed({3'b000, ppsim_pkg::LIFE_FLOOR})) begin
                            r_life <= ppsim_pkg::LIFE_FLOOR;
                        end else if (n_life_sum > $signed({3'b000, ppsim_pkg::AGE_MAX})) begin
                            r_life <= ppsim_pkg::AGE_MAX;
                        end else begin
                            r_life <= n_life_sum[23:0];
                        end
                    end
                endcase
            end
            S_COS: r_trig <= w_sin[n_idx];
            S_VXM: r_trig <= w_sin[n_idx];
            S_VYM: r_vx   <= n_step;
            S_TK_RD: r_rec <= w_rdata;
            S_TK_VY: r_rec.vel_y <= r_rec.vel_y + n_step;
            S_TK_X:  r_rec.pos_x <= r_rec.pos_x + n_step;
            S_TK_Y: begin
                r_rec.pos_y <= r_rec.pos_y + n_step;
                r_rec.age   <= n_age_sum[24] ? ppsim_pkg::AGE_MAX : n_age_sum[23:0];
            end
            S_OUT_RD: begin
                r_rec <= w_rdata;
                r_rem <= w_rdata.age;
                r_q   <= '0;
            end
            S_OUT_DIV: begin
                r_rem <= n_rem_ge ? n_rem_sub[23:0] : n_rem2[23:0];
                r_q   <= {r_q[6:0], n_rem_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // Sequencer, configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= 32'd1;
            r_rate      <= '0;
            r_angles    <= '0;
            r_speed     <= 31'd65536;
            r_sspread   <= '0;
            r_blife     <= 24'd65536;
            r_lspread   <= '0;
            r_grav      <= '0;
            r_rng       <= 32'd1;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_i         <= '0;
            r_nspawn    <= '0;
            r_draw      <= DRAW_ANG;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Register writes must arrive only while idle; the block does not enforce it.
            if (n_cfg_wr) begin
                unique case (paddr[4:2])
                    ppsim_pkg::REG_SEED: begin
                        r_seed <= pwdata;
                        r_rng  <= (pwdata == '0) ? 32'd1 : pwdata;
                    end
                    ppsim_pkg::REG_RATE:    r_rate    <= pwdata[30:0];
                    ppsim_pkg::REG_ANGLES:  r_angles  <= pwdata;
                    ppsim_pkg::REG_SPEED:   r_speed   <= pwdata[30:0];
                    ppsim_pkg::REG_SSPREAD: r_sspread <= pwdata[30:0];
                    ppsim_pkg::REG_BLIFE:   r_blife   <= pwdata[23:0];
                    ppsim_pkg::REG_LSPREAD: r_lspread <= pwdata[23:0];
                    default:                r_grav    <= pwdata;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_i <= '0;
                        if (i_in.func) begin
                            r_nspawn <= {9'd0, i_in.burst_count};
                            r_state  <= S_SP_CHK;
                        end else if (i_in.emitting && (r_rate != '0)) begin
                            r_state <= S_ACC_MUL;
                        end else begin
                            r_state <= S_TK_CHK;
                        end
                    end
                end
                S_ACC_MUL: r_state <= S_ACC_ADD;
                S_ACC_ADD: begin
                    r_acc    <= n_acc_sum[15:0];
                    r_nspawn <= n_acc_sum[31:16];
                    r_state  <= S_SP_CHK;
                end
                // Spawn while credit remains and the pool has room.
                S_SP_CHK: begin
                    r_draw <= DRAW_ANG;
                    if ((r_nspawn != '0) && (r_cnt < MAX_CNT)) begin
                        r_state <= S_DRAW;
                    end else if (r_func) begin
                        r_state <= S_OUT_START;
                    end else begin
                        r_state <= S_TK_CHK;
                    end
                end
                S_DRAW: begin
                    r_rng   <= n_rng;
                    r_state <= S_DMUL;
                end
                S_DMUL: r_state <= S_DADD;
                S_DADD: begin
                    if (r_draw == DRAW_LIFE) begin
                        r_state <= S_COS;
                    end else begin
                        r_draw  <= r_draw + 2'd1;
                        r_state <= S_DRAW;
                    end
                end
                S_COS: r_state <= S_VXM;
                S_VXM: r_state <= S_VYM;
                S_VYM: r_state <= S_SP_WR;
                S_SP_WR: begin
                    r_cnt    <= r_cnt + CW'(1);
                    r_nspawn <= r_nspawn - 16'd1;
                    r_state  <= S_SP_CHK;
                end
                // Update walk over the pool.
                S_TK_CHK: begin
                    r_state <= (r_i < r_cnt) ? S_TK_RD : S_OUT_START;
                end
                S_TK_RD: r_state <= S_TK_VY;
                S_TK_VY: r_state <= S_TK_MX;
                S_TK_MX: r_state <= S_TK_X;
                S_TK_X:  r_state <= S_TK_MY;
                S_TK_MY: r_state <= S_TK_Y;
                S_TK_Y:  r_state <= S_TK_DEC;
                S_TK_DEC: begin
                    if (r_rec.age >= r_rec.life) begin
                        r_state <= S_TK_MV;
                    end else begin
                        r_i     <= n_next_i;
                        r_state <= S_TK_CHK;
                    end
                end
                // The last particle is moved into the gap.
                S_TK_MV: begin
                    r_cnt   <= n_last_idx;
                    r_state <= S_TK_CHK;
                end
                // Listing of the pool.
                S_OUT_START: begin
                    r_i <= '0;
                    if (r_cnt == '0) begin
                        r_out.has_particle <= 1'b0;
                        r_out.pos_x        <= '0;
                        r_out.pos_y        <= '0;
                        r_out.life_frac    <= '0;
                        r_out.live_count   <= '0;
                        r_out.last         <= 1'b1;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_OUT_WAIT;
                    end else begin
                        r_state <= S_OUT_RD;
                    end
                end
                S_OUT_RD: begin
                    r_k     <= '0;
                    r_state <= S_OUT_DIV;
                end
                S_OUT_DIV: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_state <= S_OUT_PUT;
                    end
                end
                S_OUT_PUT: begin
                    r_out.has_particle <= 1'b1;
                    r_out.pos_x        <= r_rec.pos_x;
                    r_out.pos_y        <= r_rec.pos_y;
                    r_out.life_frac    <= (r_rec.age >= r_rec.life) ? 8'hFF : r_q;
                    r_out.live_count   <= 7'(r_cnt);
                    r_out.last         <= (n_next_i == r_cnt);
                    r_out_valid        <= 1'b1;
                    r_state            <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (n_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= n_next_i;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/ppsim_ram.sv
`default_nettype none

module ppsim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/ppsim_checker.sv
`default_nettype none

module ppsim_checker #(
    parameter int MAX_PARTICLES = ppsim_pkg::MAX_PARTICLES_DEF
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire ppsim_pkg::t_out o_out
);

    // A stalled result word is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // No new word is taken while a result is pending.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    // An accepted word closes the input on the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not closed after acceptance");

    // An empty listing is a single last word with a zero count.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.has_particle |-> o_out.last && (o_out.live_count == 7'd0))
        else $error("malformed empty listing");

    // The pool never holds more than its size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.live_count <= 7'(MAX_PARTICLES)))
        else $error("live count beyond pool size");

endmodule

bind particle_pool_simulator ppsim_checker #(
    .MAX_PARTICLES (MAX_PARTICLES)
) u_ppsim_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire
